[src/rcbi_pkg.sv]
// shared constants, codes and types of the row-column block interleaver
// no dependencies; every other file of the block imports this package

package rcbi_pkg;

    // matrix geometry
    localparam int ROWS        = 255;
    localparam int MAX_COLUMNS = 32;

    // derived widths
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW        = $clog2(MAX_COLUMNS + 1);
    localparam int CNT_W     = $clog2(ROWS * MAX_COLUMNS + 1);
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int COLS_W    = 6;
    localparam int PADN_W    = 13;
    localparam int CALC_W    = ((CNT_W > PADN_W) ? CNT_W : PADN_W) + 1;
    localparam int ADDR_W    = 1 + ROW_W + COL_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COLUMNS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PAD_COUNT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PAD_VALUE = 2'd3;

    // register reset values
    localparam logic              RST_MODE      = 1'b0;
    localparam logic [COLS_W-1:0] RST_COLUMNS   = 6'd20;
    localparam logic [PADN_W-1:0] RST_PAD_COUNT = 13'd0;
    localparam logic [BYTE_W-1:0] RST_PAD_VALUE = 8'd48;

    typedef struct packed {
        logic              mode;
        logic [COLS_W-1:0] columns;
        logic [PADN_W-1:0] pad_count;
        logic [BYTE_W-1:0] pad_value;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic use_pad;
        logic block_end;
        logic stream_last;
    } t_flags;

    typedef struct packed {
        logic   valid;
        t_flags flags;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              block_end;
        logic              stream_last;
    } t_result;

endpackage

[src/rcbi_front.sv]
// front part: takes each transfer, classifies the command, runs the fill and
// drain counters and issues store writes and reads; depends on rcbi_pkg

module rcbi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [rcbi_pkg::CMD_W-1:0]    i_command,
    input  logic [rcbi_pkg::BYTE_W-1:0]   i_data_byte,
    input  rcbi_pkg::t_cfg                i_cfg,
    output rcbi_pkg::t_mem_wr             o_wr,
    output rcbi_pkg::t_mem_rd             o_rd,
    output rcbi_pkg::t_req                o_req
);
    import rcbi_pkg::*;

    // control state
    logic             r_fill_bank, n_fill_bank;
    logic [ROW_W-1:0] r_fill_row, n_fill_row;
    logic [COL_W-1:0] r_fill_col, n_fill_col;
    logic             r_fill_full, n_fill_full;
    logic [ROW_W-1:0] r_drain_row, n_drain_row;
    logic [COL_W-1:0] r_drain_col, n_drain_col;
    logic             r_drain_pending, n_drain_pending;
    logic             r_drain_final, n_drain_final;
    logic [CNT_W-1:0] r_drain_limit, n_drain_limit;
    logic             r_stream_ended, n_stream_ended;
    logic [CNT_W-1:0] r_final_fill, n_final_fill;

    logic [CW-1:0]     eff_c;
    logic [CALC_W-1:0] bsize, fill_a, fill_b, fc, final_limit;
    logic [CALC_W-1:0] drain_a, drain_b, drain_e, drain_w;
    logic              pad_sel;

    // write side
    logic              data_handover, data_write, wr_in_range;
    logic              wr_bank;
    logic [ROW_W-1:0]  wr_row, wr_row_nx;
    logic [COL_W-1:0]  wr_col, wr_col_nx;
    logic              wr_full_nx;
    logic [CALC_W-1:0] wr_row_p1, wr_col_p1;

    // drain side
    logic [CALC_W-1:0] dr_row_p1, dr_col_p1;
    logic [ROW_W-1:0]  dr_row_nx;
    logic [COL_W-1:0]  dr_col_nx;
    logic              dr_ended, dr_last;

    // handover decision
    logic              hand, hand_final;
    logic [CALC_W-1:0] hand_count;

    // effective column count and block sizes
    always_comb begin
        if (i_cfg.columns == '0) begin
            eff_c = CW'(1);
        end else if (CALC_W'(i_cfg.columns) > CALC_W'(MAX_COLUMNS)) begin
            eff_c = CW'(MAX_COLUMNS);
        end else begin
            eff_c = CW'(i_cfg.columns);
        end
    end

    assign bsize       = CALC_W'(eff_c) * CALC_W'(ROWS);
    assign final_limit = (CALC_W'(i_cfg.pad_count) >= bsize) ? CALC_W'(1)
                                                               : bsize - CALC_W'(i_cfg.pad_count);

    // bytes already in the fill bank
    assign fill_a = CALC_W'(r_fill_col) * CALC_W'(ROWS) + CALC_W'(r_fill_row);
    assign fill_b = CALC_W'(r_fill_row) * CALC_W'(eff_c) + CALC_W'(r_fill_col);
    assign fc     = r_fill_full ? bsize : (i_cfg.mode ? fill_a : fill_b);

    // drain position in emit order and in write order
    assign drain_a = CALC_W'(r_drain_col) * CALC_W'(ROWS) + CALC_W'(r_drain_row);
    assign drain_b = CALC_W'(r_drain_row) * CALC_W'(eff_c) + CALC_W'(r_drain_col);
    assign drain_e = i_cfg.mode ? drain_b : drain_a;
    assign drain_w = i_cfg.mode ? drain_a : drain_b;
    assign pad_sel = (drain_w >= CALC_W'(r_final_fill))
                  || (CALC_W'(r_drain_row) >= CALC_W'(ROWS))
                  || (CALC_W'(r_drain_col) >= CALC_W'(MAX_COLUMNS));

    // fill counter step
    assign data_handover = r_fill_full && !r_drain_pending;
    assign data_write    = !r_fill_full || data_handover;
    assign wr_bank       = data_handover ? ~r_fill_bank : r_fill_bank;
    assign wr_row        = data_handover ? '0 : r_fill_row;
    assign wr_col        = data_handover ? '0 : r_fill_col;
    assign wr_row_p1     = CALC_W'(wr_row) + CALC_W'(1);
    assign wr_col_p1     = CALC_W'(wr_col) + CALC_W'(1);
    assign wr_in_range   = (CALC_W'(wr_row) < CALC_W'(ROWS))
                        && (CALC_W'(wr_col) < CALC_W'(MAX_COLUMNS));

    always_comb begin
        wr_row_nx  = wr_row;
        wr_col_nx  = wr_col;
        wr_full_nx = 1'b0;
        if (!i_cfg.mode) begin
            if (wr_col_p1 >= CALC_W'(eff_c)) begin
                wr_col_nx = '0;
                if (wr_row_p1 >= CALC_W'(ROWS)) begin
                    wr_row_nx  = '0;
                    wr_full_nx = 1'b1;
                end else begin
                    wr_row_nx = ROW_W'(wr_row_p1);
                end
            end else begin
                wr_col_nx = COL_W'(wr_col_p1);
            end
        end else begin
            if (wr_row_p1 >= CALC_W'(ROWS)) begin
                wr_row_nx = '0;
                if (wr_col_p1 >= CALC_W'(eff_c)) begin
                    wr_col_nx  = '0;
                    wr_full_nx = 1'b1;
                end else begin
                    wr_col_nx = COL_W'(wr_col_p1);
                end
            end else begin
                wr_row_nx = ROW_W'(wr_row_p1);
            end
        end
    end

    // drain counter step
    assign dr_row_p1 = CALC_W'(r_drain_row) + CALC_W'(1);
    assign dr_col_p1 = CALC_W'(r_drain_col) + CALC_W'(1);

    always_comb begin
        dr_row_nx = r_drain_row;
        dr_col_nx = r_drain_col;
        dr_ended  = 1'b0;
        if (!i_cfg.mode) begin
            if (dr_row_p1 >= CALC_W'(ROWS)) begin
                dr_row_nx = '0;
                dr_col_nx = COL_W'(dr_col_p1);
                dr_ended  = (dr_col_p1 >= CALC_W'(eff_c));
            end else begin
                dr_row_nx = ROW_W'(dr_row_p1);
            end
        end else begin
            if (dr_col_p1 >= CALC_W'(eff_c)) begin
                dr_col_nx = '0;
                dr_row_nx = ROW_W'(dr_row_p1);
                dr_ended  = (dr_row_p1 >= CALC_W'(ROWS));
            end else begin
                dr_col_nx = COL_W'(dr_col_p1);
            end
        end
    end

    assign dr_last = ((drain_e + CALC_W'(1)) >= CALC_W'(r_drain_limit)) || dr_ended;

    // command handling, then handover of a full fill bank or, at stream end, of the last one
    always_comb begin
        n_fill_bank     = r_fill_bank;
        n_fill_row      = r_fill_row;
        n_fill_col      = r_fill_col;
        n_fill_full     = r_fill_full;
        n_drain_row     = r_drain_row;
        n_drain_col     = r_drain_col;
        n_drain_pending = r_drain_pending;
        n_drain_final   = r_drain_final;
        n_drain_limit   = r_drain_limit;
        n_stream_ended  = r_stream_ended;
        n_final_fill    = r_final_fill;
        hand            = 1'b0;
        hand_final      = 1'b0;
        hand_count      = bsize;
        o_wr            = '0;
        o_rd            = '0;
        o_req           = '0;
        if (i_accept) begin
            case (i_command)
                CMD_DATA: begin
                    if (!r_stream_ended) begin
                        if (data_handover) begin
                            n_drain_pending = 1'b1;
                            n_drain_row     = '0;
                            n_drain_col     = '0;
                            n_drain_final   = 1'b0;
                            n_final_fill    = CNT_W'(bsize);
                            n_drain_limit   = CNT_W'(bsize);
                        end
                        if (data_write) begin
                            o_wr.en     = wr_in_range;
                            o_wr.addr   = {wr_bank, wr_row, wr_col};
                            o_wr.data   = i_data_byte;
                            n_fill_bank = wr_bank;
                            n_fill_row  = wr_row_nx;
                            n_fill_col  = wr_col_nx;
                            n_fill_full = wr_full_nx;
                        end
                    end
                end
                CMD_END: begin
                    if (!r_stream_ended) begin
                        n_stream_ended = 1'b1;
                        if (fc == '0 && r_drain_pending) begin
                            n_drain_final = 1'b1;
                        end
                    end
                end
                CMD_DRAIN: begin
                    if (r_drain_pending) begin
                        o_rd.en                 = 1'b1;
                        o_rd.addr               = {~r_fill_bank, r_drain_row, r_drain_col};
                        o_req.valid             = 1'b1;
                        o_req.flags.use_pad     = pad_sel;
                        o_req.flags.block_end   = dr_last;
                        o_req.flags.stream_last = dr_last && r_drain_final;
                        n_drain_row             = dr_row_nx;
                        n_drain_col             = dr_col_nx;
                        if (dr_last) begin
                            n_drain_pending = 1'b0;
                            n_drain_final   = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (!n_drain_pending) begin
                if (n_fill_full && (!i_cfg.mode || n_stream_ended)) begin
                    hand       = 1'b1;
                    hand_final = n_stream_ended;
                    hand_count = bsize;
                end else if (n_stream_ended && fc != '0) begin
                    hand       = 1'b1;
                    hand_final = 1'b1;
                    hand_count = fc;
                end else if (n_stream_ended) begin
                    n_stream_ended = 1'b0;
                end
            end

            if (hand) begin
                n_drain_pending = 1'b1;
                n_drain_row     = '0;
                n_drain_col     = '0;
                n_drain_final   = hand_final;
                n_final_fill    = CNT_W'(hand_count);
                n_drain_limit   = (hand_final && i_cfg.mode) ? CNT_W'(final_limit)
                                                             : CNT_W'(bsize);
                n_fill_bank     = ~n_fill_bank;
                n_fill_row      = '0;
                n_fill_col      = '0;
                n_fill_full     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_bank     <= 1'b0;
            r_fill_row      <= '0;
            r_fill_col      <= '0;
            r_fill_full     <= 1'b0;
            r_drain_row     <= '0;
            r_drain_col     <= '0;
            r_drain_pending <= 1'b0;
            r_drain_final   <= 1'b0;
            r_drain_limit   <= '0;
            r_stream_ended  <= 1'b0;
            r_final_fill    <= '0;
        end else begin
            r_fill_bank     <= n_fill_bank;
            r_fill_row      <= n_fill_row;
            r_fill_col      <= n_fill_col;
            r_fill_full     <= n_fill_full;
            r_drain_row     <= n_drain_row;
            r_drain_col     <= n_drain_col;
            r_drain_pending <= n_drain_pending;
            r_drain_final   <= n_drain_final;
            r_drain_limit   <= n_drain_limit;
            r_stream_ended  <= n_stream_ended;
            r_final_fill    <= n_final_fill;
        end
    end

endmodule

[src/rcbi_store.sv]
// two-bank byte store: one write port, one read port with registered data
// depends on rcbi_pkg for the address width and depth

module rcbi_store (
    input  logic                        i_clk,
    input  rcbi_pkg::t_mem_wr           i_wr,
    input  rcbi_pkg::t_mem_rd           i_rd,
    output logic [rcbi_pkg::BYTE_W-1:0] o_q
);
    import rcbi_pkg::*;

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_q <= r_mem[i_rd.addr];
        end
    end

    assign o_q = r_q;

endmodule

[src/rcbi_queue.sv]
// short result queue feeding the master stream side
// depends on rcbi_pkg for the depth and the result type

module rcbi_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  rcbi_pkg::t_result           i_data,
    input  logic                        i_ready,
    output logic                        o_valid,
    output rcbi_pkg::t_result           o_data,
    output logic [rcbi_pkg::QCNT_W-1:0] o_count
);
    import rcbi_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/row_column_block_interleaver_unit.sv]
// top level of the row-column block interleaver: configuration registers,
// read stage and the wiring of rcbi_front, rcbi_store and rcbi_queue
//
// usage
//   s_axis carries commands: tuser selects data byte, end of stream or drain
//   tick, tdata carries the byte. every drain tick that finds a block ready
//   yields one byte on m_axis; other commands yield nothing
//   m_axis tlast marks the last byte of a block, tuser the last of the stream
//   the config port writes mode, columns, pad count and pad byte by index;
//   the user must write it only while no transfer is in flight, which the block leaves to the user
// throughput: one input transfer per cycle while s_axis_tready is high, any mix of commands
// result path: the store read data and the flags of a drain tick are registered
//   in the read stage, then the result is written into the queue for m_axis
// stall: results wait in a four-entry queue; s_axis_tready drops only when
//   the queue and the read stage together hold four results, so input keeps
//   flowing while the receiver takes one transfer per cycle
// reset: synchronous, active low; counters, handshake state and registers
//   return to their defaults at once, with no clearing pass; store contents
//   stay as they were and are only used after being written

module row_column_block_interleaver_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream: command transfers
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]                      s_axis_tuser,   // [1:0] command
    // master stream: reordered bytes
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
    output logic                            m_axis_tlast,   // block_end
    output logic                            m_axis_tuser,   // [0] stream_last
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [rcbi_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rcbi_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import rcbi_pkg::*;

    t_cfg              r_cfg;
    logic              in_accept;
    t_mem_wr           mem_wr;
    t_mem_rd           mem_rd;
    t_req              req;
    logic [BYTE_W-1:0] ram_q;

    // read stage: flags travel alongside the registered store data
    logic              r_s1_valid;
    t_flags            r_s1_flags;
    t_result           s1_result;

    logic              q_valid;
    t_result           q_data;
    logic [QCNT_W-1:0] q_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= RST_MODE;
            r_cfg.columns   <= RST_COLUMNS;
            r_cfg.pad_count <= RST_PAD_COUNT;
            r_cfg.pad_value <= RST_PAD_VALUE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:      r_cfg.mode      <= i_cfg_wdata[0];
                REG_COLUMNS:   r_cfg.columns   <= i_cfg_wdata[COLS_W-1:0];
                REG_PAD_COUNT: r_cfg.pad_count <= i_cfg_wdata[PADN_W-1:0];
                REG_PAD_VALUE: r_cfg.pad_value <= i_cfg_wdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // room for every result that may still land in the queue
    assign s_axis_tready = (QCNT_W'(q_count) + QCNT_W'(r_s1_valid)) < QCNT_W'(QUEUE_DEPTH);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    rcbi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_command   (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .i_cfg       (r_cfg),
        .o_wr        (mem_wr),
        .o_rd        (mem_rd),
        .o_req       (req)
    );

    rcbi_store u_store (
        .i_clk (i_clk),
        .i_wr  (mem_wr),
        .i_rd  (mem_rd),
        .o_q   (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.valid) begin
            r_s1_flags <= req.flags;
        end
    end

    // past the end of the written data the pad byte stands in
    assign s1_result.out_byte    = r_s1_flags.use_pad ? r_cfg.pad_value : ram_q;
    assign s1_result.block_end   = r_s1_flags.block_end;
    assign s1_result.stream_last = r_s1_flags.stream_last;

    rcbi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_result),
        .i_ready (m_axis_tready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = q_data.out_byte;
    assign m_axis_tlast  = q_data.block_end;
    assign m_axis_tuser  = q_data.stream_last;

endmodule

[src/rcbi_checker.sv]
// port-level checks for the row-column block interleaver, bound to the top
// depends on rcbi_pkg for the command codes

module rcbi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);
    import rcbi_pkg::*;

    // the end of the stream is always the end of a block
    a_stream_last_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("stream end without block end");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // input only backs up when results are waiting
    a_backpressure_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // a result appears on an empty output only from a drain tick that passed the read stage and the queue
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid)
            |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_DRAIN, 2))
        else $error("result without a drain tick");

endmodule

bind row_column_block_interleaver_unit rcbi_checker u_rcbi_checker (.*);
